/* rtl/arp_pkg.sv */
// Shared types and character constants for the address range parser.
package arp_pkg;

   // Characters recognised by the parser
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      PH_SCAN1 = 4'd0,
      PH_PEND1 = 4'd1,
      PH_NUM1  = 4'd2,
      PH_SCAN2 = 4'd3,
      PH_PEND2 = 4'd4,
      PH_NUM2  = 4'd5,
      PH_DONE  = 4'd6
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        hex_mode;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic        relative_flag;
      logic [15:0] char_count;
   } state_type;

   typedef struct packed {
      logic [31:0] first_addr;
      logic [31:0] last_addr;
      logic [15:0] consumed;
      logic        ok;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_SCAN1,
      hex_mode:      1'b0,
      first_value:   32'd0,
      second_value:  32'd0,
      relative_flag: 1'b0,
      char_count:    16'd0
   };

endpackage

/* rtl/arp_step.sv */
// Per-character parser update: next state and the result it may produce.
module arp_step (
   input  arp_pkg::state_type  state_i,
   input  logic [7:0]          ch_i,
   output arp_pkg::state_type  next_o,
   output logic                emit_o,
   output arp_pkg::result_type result_o
);

   logic        is_scan;
   logic        is_pend;
   logic        is_num;
   logic        is_second;
   logic        pre;
   logic        num_active;
   logic        num_hex;
   logic [31:0] cur_val;
   logic [31:0] first_eff;
   logic [31:0] end_val;
   logic [31:0] acc;
   logic [7:0]  d_tmp;
   logic [3:0]  dval;
   logic        dvalid;
   logic        take_digit;
   logic        take_sign;
   logic        num_end;
   logic [15:0] count_bump;

   // Phase decode, lookahead resolution and digit arithmetic
   always_comb begin
      is_scan   = (state_i.phase == arp_pkg::PH_SCAN1) || (state_i.phase == arp_pkg::PH_SCAN2);
      is_pend   = (state_i.phase == arp_pkg::PH_PEND1) || (state_i.phase == arp_pkg::PH_PEND2);
      is_num    = (state_i.phase == arp_pkg::PH_NUM1) || (state_i.phase == arp_pkg::PH_NUM2);
      is_second = (state_i.phase == arp_pkg::PH_SCAN2) || (state_i.phase == arp_pkg::PH_PEND2) ||
                  (state_i.phase == arp_pkg::PH_NUM2);

      // a nonzero digit while scanning, or a pending zero not followed by x,
      // drops straight into a fresh decimal number on this character
      pre = (is_scan && (ch_i >= arp_pkg::CH_ONE) && (ch_i <= arp_pkg::CH_NINE)) ||
            (is_pend && (ch_i != arp_pkg::CH_LOWER_X));
      num_active = is_num || pre;
      num_hex    = pre ? 1'b0 : state_i.hex_mode;
      cur_val    = pre ? 32'd0 : (is_second ? state_i.second_value : state_i.first_value);
      first_eff  = is_second ? state_i.first_value : cur_val;
      end_val    = is_second ? (state_i.relative_flag ? state_i.first_value + cur_val : cur_val)
                             : first_eff;

      // digit value in the current base
      dvalid = 1'b0;
      d_tmp  = ch_i - arp_pkg::CH_ZERO;
      if ((ch_i >= arp_pkg::CH_ZERO) && (ch_i <= arp_pkg::CH_NINE)) begin
         dvalid = 1'b1;
      end else if (num_hex && (ch_i >= arp_pkg::CH_UPPER_A) && (ch_i <= arp_pkg::CH_UPPER_F)) begin
         dvalid = 1'b1;
         d_tmp  = ch_i - (arp_pkg::CH_UPPER_A - 8'd10);
      end else if (num_hex && (ch_i >= arp_pkg::CH_LOWER_A) && (ch_i <= arp_pkg::CH_LOWER_F)) begin
         dvalid = 1'b1;
         d_tmp  = ch_i - (arp_pkg::CH_LOWER_A - 8'd10);
      end
      dval = d_tmp[3:0];

      // times sixteen is a shift, times ten is two shifts and an add
      if (num_hex) begin
         acc = {cur_val[27:0], dval};
      end else begin
         acc = {cur_val[28:0], 3'b000} + {cur_val[30:0], 1'b0} + {28'd0, dval};
      end

      take_digit = num_active && dvalid;
      take_sign  = num_active && !is_second && !take_digit &&
                   ((ch_i == arp_pkg::CH_MINUS) || (ch_i == arp_pkg::CH_PLUS));
      num_end    = num_active && !take_digit && !take_sign;

      // saturating character count
      count_bump = state_i.char_count +
                   {15'd0, state_i.char_count != arp_pkg::COUNT_MAX};
   end

   // Next state
   always_comb begin
      next_o = state_i;
      unique case (state_i.phase)
         arp_pkg::PH_SCAN1, arp_pkg::PH_SCAN2: begin
            if (ch_i == arp_pkg::CH_NUL) begin
               next_o = arp_pkg::STATE_RESET;
            end else if (ch_i == arp_pkg::CH_DOLLAR) begin
               next_o.char_count = count_bump;
               next_o.hex_mode   = 1'b1;
               if (is_second) begin
                  next_o.second_value = 32'd0;
                  next_o.phase        = arp_pkg::PH_NUM2;
               end else begin
                  next_o.first_value = 32'd0;
                  next_o.phase       = arp_pkg::PH_NUM1;
               end
            end else if (ch_i == arp_pkg::CH_ZERO) begin
               next_o.char_count = count_bump;
               next_o.phase      = is_second ? arp_pkg::PH_PEND2 : arp_pkg::PH_PEND1;
            end else if (!pre) begin
               next_o.char_count = count_bump;
            end
         end
         arp_pkg::PH_PEND1, arp_pkg::PH_PEND2: begin
            if (!pre) begin
               next_o.char_count = count_bump;
               next_o.hex_mode   = 1'b1;
               if (is_second) begin
                  next_o.second_value = 32'd0;
                  next_o.phase        = arp_pkg::PH_NUM2;
               end else begin
                  next_o.first_value = 32'd0;
                  next_o.phase       = arp_pkg::PH_NUM1;
               end
            end
         end
         arp_pkg::PH_NUM1, arp_pkg::PH_NUM2: begin
            next_o = state_i;
         end
         default: begin
            if (ch_i == arp_pkg::CH_NUL) begin
               next_o = arp_pkg::STATE_RESET;
            end
         end
      endcase

      // number accumulation, range operator or end of expression
      if (num_active) begin
         next_o.hex_mode = num_hex;
         if (take_digit) begin
            next_o.char_count = count_bump;
            if (is_second) begin
               next_o.second_value = acc;
               next_o.phase        = arp_pkg::PH_NUM2;
            end else begin
               next_o.first_value = acc;
               next_o.phase       = arp_pkg::PH_NUM1;
            end
         end else if (take_sign) begin
            next_o.char_count    = count_bump;
            next_o.first_value   = cur_val;
            next_o.relative_flag = (ch_i == arp_pkg::CH_PLUS);
            next_o.phase         = arp_pkg::PH_SCAN2;
         end else if (ch_i == arp_pkg::CH_NUL) begin
            next_o = arp_pkg::STATE_RESET;
         end else begin
            next_o.phase = arp_pkg::PH_DONE;
         end
      end
   end

   // Result
   always_comb begin
      emit_o   = 1'b0;
      result_o = '0;
      if (num_end) begin
         emit_o              = 1'b1;
         result_o.first_addr = first_eff;
         result_o.last_addr  = end_val;
         result_o.consumed   = state_i.char_count;
         result_o.ok         = 1'b1;
      end else if (is_scan && (ch_i == arp_pkg::CH_NUL)) begin
         // string ended with a number missing
         emit_o              = 1'b1;
         result_o.first_addr = is_second ? state_i.first_value : 32'd0;
         result_o.last_addr  = is_second ? state_i.first_value : 32'd0;
      end
   end

endmodule

/* rtl/arp_result_reg.sv */
// Result register for the response channel.
module arp_result_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_i,
   input  arp_pkg::result_type result_i,
   output logic                space_o,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output arp_pkg::result_type rsp_o
);

   logic                valid_ff;
   logic                valid_in;
   arp_pkg::result_type data_ff;

   // free when empty or when the held transaction leaves this cycle
   assign space_o = !valid_ff || !rsp_stall;

   always_comb begin
      if (load_i) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load_i) begin
         data_ff <= result_i;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_o     = data_ff;

endmodule

/* rtl/address_range_parser.sv */
// Top level of the address range parser.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    ch (8)
//   rsp      out        rsp_valid/stall    first_addr, last_addr (32), consumed (16), ok
//
// One character is taken per cycle while req_stall is low; the whole update for a
// character sits between the parser state register and the result register.
// A result appears on rsp in the cycle after the character that ends the expression.
// Synchronous reset returns the parser to scanning for the first number.
// req_stall is raised only while a result is held and rsp_stall is high.
module address_range_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_first_addr,
   output logic [31:0] rsp_last_addr,
   output logic [15:0] rsp_consumed,
   output logic        rsp_ok
);

   arp_pkg::state_type  state_ff;
   arp_pkg::state_type  state_in;
   arp_pkg::result_type step_result;
   arp_pkg::result_type rsp_data;
   logic                step_emit;
   logic                space;
   logic                accept;

   assign req_stall = !space;
   assign accept    = req_valid && space;

   arp_step u_step (
      .state_i  (state_ff),
      .ch_i     (req_ch),
      .next_o   (state_in),
      .emit_o   (step_emit),
      .result_o (step_result)
   );

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arp_pkg::STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   arp_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load_i    (accept && step_emit),
      .result_i  (step_result),
      .space_o   (space),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_o     (rsp_data)
   );

   assign rsp_first_addr = rsp_data.first_addr;
   assign rsp_last_addr  = rsp_data.last_addr;
   assign rsp_consumed   = rsp_data.consumed;
   assign rsp_ok         = rsp_data.ok;

endmodule

/* tb/address_range_parser_test.sv */
// Self-checking testbench for the address range parser: directed and random strings.
module address_range_parser_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_first_addr;
   logic [31:0] rsp_last_addr;
   logic [15:0] rsp_consumed;
   logic        rsp_ok;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int chars_sent    = 0;
   int error_count   = 0;

   // Predicted parser state
   arp_pkg::phase_type ps_phase;
   logic               ps_hex;
   logic [31:0]        ps_first;
   logic [31:0]        ps_second;
   logic               ps_relative;
   logic [15:0]        ps_count;

   arp_pkg::result_type expected_ranges[$];

   address_range_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_first_addr (rsp_first_addr),
      .rsp_last_addr  (rsp_last_addr),
      .rsp_consumed   (rsp_consumed),
      .rsp_ok         (rsp_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void clear_parser();
      ps_phase    = arp_pkg::PH_SCAN1;
      ps_hex      = 1'b0;
      ps_first    = 32'd0;
      ps_second   = 32'd0;
      ps_relative = 1'b0;
      ps_count    = 16'd0;
   endfunction

   function automatic void bump_count();
      if (ps_count != arp_pkg::COUNT_MAX) ps_count++;
   endfunction

   // digit weight of a character, -1 when it is not a digit in this base
   function automatic int digit_of(input logic [7:0] c, input logic hex);
      if (c >= arp_pkg::CH_ZERO && c <= arp_pkg::CH_NINE)
         return int'(c - arp_pkg::CH_ZERO);
      if (hex && c >= arp_pkg::CH_UPPER_A && c <= arp_pkg::CH_UPPER_F)
         return int'(c - arp_pkg::CH_UPPER_A) + 10;
      if (hex && c >= arp_pkg::CH_LOWER_A && c <= arp_pkg::CH_LOWER_F)
         return int'(c - arp_pkg::CH_LOWER_A) + 10;
      return -1;
   endfunction

   // advance the predicted state by one character, queueing any range it completes
   task automatic parse_char(input logic [7:0] c);
      logic                again;
      logic                second;
      int                  digit;
      logic [31:0]         base;
      arp_pkg::result_type res;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (ps_phase)
            arp_pkg::PH_SCAN1, arp_pkg::PH_SCAN2: begin
               second = (ps_phase == arp_pkg::PH_SCAN2);
               if (c == arp_pkg::CH_NUL) begin
                  res.first_addr = second ? ps_first : 32'd0;
                  res.last_addr  = res.first_addr;
                  res.consumed   = 16'd0;
                  res.ok         = 1'b0;
                  expected_ranges.push_back(res);
                  clear_parser();
                  return;
               end
               if (c == arp_pkg::CH_DOLLAR) begin
                  bump_count();
                  ps_hex = 1'b1;
                  if (second) ps_second = 32'd0; else ps_first = 32'd0;
                  ps_phase = second ? arp_pkg::PH_NUM2 : arp_pkg::PH_NUM1;
               end else if (c == arp_pkg::CH_ZERO) begin
                  bump_count();
                  ps_phase = second ? arp_pkg::PH_PEND2 : arp_pkg::PH_PEND1;
               end else if (c >= arp_pkg::CH_ONE && c <= arp_pkg::CH_NINE) begin
                  ps_hex = 1'b0;
                  if (second) ps_second = 32'd0; else ps_first = 32'd0;
                  ps_phase = second ? arp_pkg::PH_NUM2 : arp_pkg::PH_NUM1;
                  again = 1'b1;
               end else begin
                  bump_count();
               end
            end
            arp_pkg::PH_PEND1, arp_pkg::PH_PEND2: begin
               second = (ps_phase == arp_pkg::PH_PEND2);
               if (second) ps_second = 32'd0; else ps_first = 32'd0;
               ps_phase = second ? arp_pkg::PH_NUM2 : arp_pkg::PH_NUM1;
               if (c == arp_pkg::CH_LOWER_X) begin
                  bump_count();
                  ps_hex = 1'b1;
               end else begin
                  // the leading zero was a decimal digit; reprocess this character
                  ps_hex = 1'b0;
                  again = 1'b1;
               end
            end
            arp_pkg::PH_NUM1, arp_pkg::PH_NUM2: begin
               second = (ps_phase == arp_pkg::PH_NUM2);
               digit  = digit_of(c, ps_hex);
               base   = ps_hex ? 32'd16 : 32'd10;
               if (c != arp_pkg::CH_NUL && digit >= 0) begin
                  if (second) ps_second = ps_second * base + 32'(digit);
                  else        ps_first  = ps_first * base + 32'(digit);
                  bump_count();
               end else if (!second && (c == arp_pkg::CH_MINUS || c == arp_pkg::CH_PLUS)) begin
                  bump_count();
                  ps_relative = (c == arp_pkg::CH_PLUS);
                  ps_phase    = arp_pkg::PH_SCAN2;
               end else begin
                  res.first_addr = ps_first;
                  if (!second)          res.last_addr = ps_first;
                  else if (ps_relative) res.last_addr = ps_first + ps_second;
                  else                  res.last_addr = ps_second;
                  res.consumed = ps_count;
                  res.ok       = 1'b1;
                  expected_ranges.push_back(res);
                  if (c == arp_pkg::CH_NUL) clear_parser();
                  else                      ps_phase = arp_pkg::PH_DONE;
               end
            end
            default: begin
               if (c == arp_pkg::CH_NUL) clear_parser();
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- driving
   // one character transaction; sender idles at random before driving it
   task automatic send_char(input logic [7:0] c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(c);
      chars_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(arp_pkg::CH_NUL);
   endtask

   function automatic logic [7:0] hex_char(input int d);
      if (d < 10) return arp_pkg::CH_ZERO + 8'(d);
      return ($urandom_range(1) ? arp_pkg::CH_UPPER_A : arp_pkg::CH_LOWER_A) + 8'(d - 10);
   endfunction

   // a character that can never start a number
   function automatic logic [7:0] pick_junk();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while ((c >= arp_pkg::CH_ZERO && c <= arp_pkg::CH_NINE) || c == arp_pkg::CH_DOLLAR);
      return c;
   endfunction

   task automatic send_number();
      int fmt;
      int len;
      fmt = $urandom_range(2);
      len = ($urandom_range(3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      // occasionally a hex prefix with no digits behind it
      if (fmt != 0 && $urandom_range(9) == 0) len = 0;
      if (fmt == 1) send_char(arp_pkg::CH_DOLLAR);
      if (fmt == 2) begin
         send_char(arp_pkg::CH_ZERO);
         send_char(arp_pkg::CH_LOWER_X);
      end
      for (int i = 0; i < len; i++) begin
         if (fmt == 0) send_char(arp_pkg::CH_ZERO + 8'($urandom_range(9)));
         else          send_char(hex_char($urandom_range(15)));
      end
   endtask

   // range expression with random content, junk around it; not always well-formed
   task automatic send_expression();
      int n;
      n = $urandom_range(3);
      repeat (n) send_char(pick_junk());
      send_number();
      case ($urandom_range(3))
         0: begin
            send_char(arp_pkg::CH_MINUS);
            if ($urandom_range(9) != 0) send_number();
         end
         1: begin
            send_char(arp_pkg::CH_PLUS);
            if ($urandom_range(9) != 0) send_number();
         end
         default: ;
      endcase
      n = $urandom_range(3);
      repeat (n) send_char(8'($urandom_range(1, 255)));
      send_char(arp_pkg::CH_NUL);
   endtask

   // random bytes biased towards the characters the parser cares about
   task automatic send_noise();
      int n;
      n = $urandom_range(10);
      repeat (n) begin
         if ($urandom_range(1)) begin
            case ($urandom_range(5))
               0: send_char(arp_pkg::CH_ZERO);
               1: send_char(arp_pkg::CH_LOWER_X);
               2: send_char(arp_pkg::CH_DOLLAR);
               3: send_char(arp_pkg::CH_MINUS);
               4: send_char(arp_pkg::CH_PLUS);
               default: send_char(hex_char($urandom_range(15)));
            endcase
         end else begin
            send_char(8'($urandom_range(1, 255)));
         end
      end
      send_char(arp_pkg::CH_NUL);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed_ranges();
      send_string("");
      send_string("123");
      send_string("$FF-$100");
      send_string("0x1f+0x10,rest");
      send_string("0");
      send_string("07");
      send_string("0x");
      send_string("$g");
      send_string("12-");
      send_string("12+");
      send_string(" junk 42");
      send_string("4294967295");
      send_string("99999999999");
      send_string("$ffffffff+1");
      send_string("$ABCDEF");
      send_string("0X5");
      send_string("5-0x");
      send_string("00x5");
      send_string("1-2-3");
      send_string("5 9 9");
      send_string("1+0x");
      send_string("0-0");
      send_string("7+$");
      // top-bit characters as junk
      send_char(8'hFF);
      send_char(8'h80);
      send_string(" 8");
   endtask

   task automatic test_random_strings(input int n_chars);
      int first;
      first = chars_sent;
      while (chars_sent - first < n_chars) begin
         if ($urandom_range(99) < 80) send_expression();
         else                          send_noise();
      end
   endtask

   // ---------------------------------------------------------------- checking
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin : check_results
      arp_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_ranges.size() == 0) begin
            $error("unexpected result: first %h last %h consumed %0d ok %b",
                   rsp_first_addr, rsp_last_addr, rsp_consumed, rsp_ok);
            error_count++;
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_first_addr !== want.first_addr) begin
               $error("first_addr: expected %h, actual %h", want.first_addr, rsp_first_addr);
               error_count++;
            end
            if (rsp_last_addr !== want.last_addr) begin
               $error("last_addr: expected %h, actual %h", want.last_addr, rsp_last_addr);
               error_count++;
            end
            if (rsp_consumed !== want.consumed) begin
               $error("consumed: expected %0d, actual %0d", want.consumed, rsp_consumed);
               error_count++;
            end
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %b, actual %b", want.ok, rsp_ok);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without a transaction on either channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else                                                        quiet_cycles++;
      end
      $display("[address_range_parser] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      clear_parser();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 83;
      test_directed_ranges();
      test_random_strings(500);

      send_idle_pct = 83;
      recv_idle_pct = 34;
      test_directed_ranges();
      test_random_strings(500);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(500);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) $display("[address_range_parser] OK");
      else                  $display("[address_range_parser] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/arp_pkg.sv
rtl/arp_step.sv
rtl/arp_result_reg.sv
rtl/address_range_parser.sv
tb/address_range_parser_test.sv
